/* rtl/core/rgbhsv_pkg.sv */
package rgbhsv_pkg;

  localparam int COMPONENT_BITS_DEFAULT = 8;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 12;
  localparam int OUT_BITS = 16;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  localparam logic REG_HUE_GAIN = 1'b0;
  localparam logic REG_SATURATION_GAIN = 1'b1;

endpackage

/* rtl/core/rgb_to_hsv_converter_top.sv */
// Channel    Handshake                  Payload
// pixel      pixel_valid, pixel_ready   red, green, blue
// hsv        hsv_valid, hsv_ready       hue, saturation, brightness
// config     write_enable               write_index, write_data
//
// One pixel enters per cycle while pixel_ready is high; each result passes through the input,
// sector, product, divider and output registers, the divider chain resolving one quotient
// bit per stage for hue and saturation side by side.
// Reset clears every stage's valid bit and sets both gains to 1.0.
// A stage holds its pixel only while the stage after it is full and held, so empty
// stages close up and pixel_ready falls only when every stage is full and the result waits.
module rgb_to_hsv_converter_top
  import rgbhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_ready,
  input  logic [COMPONENT_BITS-1:0] red,
  input  logic [COMPONENT_BITS-1:0] green,
  input  logic [COMPONENT_BITS-1:0] blue,
  output logic                      hsv_valid,
  input  logic                      hsv_ready,
  output logic [OUT_BITS-1:0]       hue,
  output logic [OUT_BITS-1:0]       saturation,
  output logic [COMPONENT_BITS-1:0] brightness,
  input  logic                      write_enable,
  input  logic                      write_index,
  input  logic [GAIN_BITS-1:0]      write_data
);

  localparam int C = COMPONENT_BITS;
  localparam int F = FRACTION_BITS;
  localparam int NW = C + 3;
  localparam int HW = NW + GAIN_FRAC;
  localparam int SW = C + GAIN_FRAC;
  localparam int HXW = NW + GAIN_BITS;
  localparam int SXW = C + GAIN_BITS;
  localparam int NS = F + 5;
  localparam int ST_DIV = 3;
  localparam logic [F-1:0] FULL_SCALE = {F{1'b1}};

  typedef struct packed {
    logic [HW-1:0] hue_rem;
    logic [HW-1:0] hue_div;
    logic [F-1:0]  hue_q;
    logic          hue_of;
    logic          hue_en;
    logic [SW-1:0] sat_rem;
    logic [SW-1:0] sat_div;
    logic [F-1:0]  sat_q;
    logic          sat_of;
    logic          sat_en;
    logic [C-1:0]  value;
  } div_t;

  logic [GAIN_BITS-1:0] hue_gain;
  logic [GAIN_BITS-1:0] saturation_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_gain <= GAIN_RESET;
      saturation_gain <= GAIN_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_HUE_GAIN: hue_gain <= write_data;
        REG_SATURATION_GAIN: saturation_gain <= write_data;
        default: hue_gain <= hue_gain;
      endcase
    end
  end

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || hsv_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pixel_ready = en[0];
  assign hsv_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  logic [C-1:0] in_red;
  logic [C-1:0] in_green;
  logic [C-1:0] in_blue;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_red <= red;
      in_green <= green;
      in_blue <= blue;
    end
  end

  logic [C-1:0]  hi;
  logic [C-1:0]  lo;
  logic [NW-1:0] r_x;
  logic [NW-1:0] g_x;
  logic [NW-1:0] b_x;
  logic [NW-1:0] d_x;
  logic [NW-1:0] d6;
  logic [NW-1:0] n_next;

  always_comb begin
    hi = in_red;
    lo = in_red;
    if (in_green > hi) hi = in_green;
    if (in_blue > hi) hi = in_blue;
    if (in_green < lo) lo = in_green;
    if (in_blue < lo) lo = in_blue;
    r_x = NW'(in_red);
    g_x = NW'(in_green);
    b_x = NW'(in_blue);
    d_x = NW'(hi) - NW'(lo);
    d6 = (d_x << 2) + (d_x << 1);
    priority if (in_red == hi) begin
      n_next = g_x - b_x;
      if (in_green < in_blue) n_next = n_next + d6;
    end else if (in_green == hi) begin
      n_next = (d_x << 1) + b_x - r_x;
    end else begin
      n_next = (d_x << 2) + r_x - g_x;
    end
  end

  logic [NW-1:0] sec_n;
  logic [NW-1:0] sec_d6;
  logic [C-1:0]  sec_d;
  logic [C-1:0]  sec_hi;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec_n <= n_next;
      sec_d6 <= d6;
      sec_d <= d_x[C-1:0];
      sec_hi <= hi;
    end
  end

  logic [HXW-1:0] prod_hue_x;
  logic [SXW-1:0] prod_sat_x;
  logic [HW-1:0]  prod_hue_div;
  logic [SW-1:0]  prod_sat_div;
  logic           prod_hue_en;
  logic           prod_sat_en;
  logic [C-1:0]   prod_value;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod_hue_x <= HXW'(sec_n) * HXW'(hue_gain);
      prod_sat_x <= SXW'(sec_d) * SXW'(saturation_gain);
      prod_hue_div <= {sec_d6, {GAIN_FRAC{1'b0}}};
      prod_sat_div <= {sec_hi, {GAIN_FRAC{1'b0}}};
      prod_hue_en <= sec_d != '0;
      prod_sat_en <= sec_hi != '0;
      prod_value <= sec_hi;
    end
  end

  div_t dv [0:F];
  div_t dv_next [0:F];

  always_comb begin
    dv_next[0].hue_rem = prod_hue_x[HW-1:0];
    dv_next[0].hue_div = prod_hue_div;
    dv_next[0].hue_q = '0;
    dv_next[0].hue_of = prod_hue_x >= HXW'(prod_hue_div);
    dv_next[0].hue_en = prod_hue_en;
    dv_next[0].sat_rem = prod_sat_x[SW-1:0];
    dv_next[0].sat_div = prod_sat_div;
    dv_next[0].sat_q = '0;
    dv_next[0].sat_of = prod_sat_x >= SXW'(prod_sat_div);
    dv_next[0].sat_en = prod_sat_en;
    dv_next[0].value = prod_value;
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [HW:0] hue_rem2;
    logic [SW:0] sat_rem2;

    always_comb begin
      dv_next[k+1] = dv[k];
      hue_rem2 = {dv[k].hue_rem, 1'b0};
      sat_rem2 = {dv[k].sat_rem, 1'b0};
      if (hue_rem2 >= {1'b0, dv[k].hue_div}) begin
        dv_next[k+1].hue_rem = HW'(hue_rem2 - {1'b0, dv[k].hue_div});
        dv_next[k+1].hue_q = {dv[k].hue_q[F-2:0], 1'b1};
      end else begin
        dv_next[k+1].hue_rem = hue_rem2[HW-1:0];
        dv_next[k+1].hue_q = {dv[k].hue_q[F-2:0], 1'b0};
      end
      if (sat_rem2 >= {1'b0, dv[k].sat_div}) begin
        dv_next[k+1].sat_rem = SW'(sat_rem2 - {1'b0, dv[k].sat_div});
        dv_next[k+1].sat_q = {dv[k].sat_q[F-2:0], 1'b1};
      end else begin
        dv_next[k+1].sat_rem = sat_rem2[SW-1:0];
        dv_next[k+1].sat_q = {dv[k].sat_q[F-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (en[ST_DIV+k]) begin
        dv[k] <= dv_next[k];
      end
    end
  end

  logic [F-1:0] hue_next;
  logic [F-1:0] sat_next;

  always_comb begin
    hue_next = '0;
    sat_next = '0;
    if (dv[F].hue_en) hue_next = dv[F].hue_of ? FULL_SCALE : dv[F].hue_q;
    if (dv[F].sat_en) sat_next = dv[F].sat_of ? FULL_SCALE : dv[F].sat_q;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      hue <= OUT_BITS'(hue_next);
      saturation <= OUT_BITS'(sat_next);
      brightness <= dv[F].value;
    end
  end

  a_black_is_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && brightness == '0 |-> hue == '0 && saturation == '0)
    else $error("black pixel gives nonzero hue or saturation");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> hsv_valid && !hsv_ready)
    else $error("input held while the output can move");

  a_sat_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[NS-2] && dv[F].sat_en && !dv[F].sat_of |-> dv[F].sat_rem < dv[F].sat_div)
    else $error("saturation remainder not below divisor");

  a_hue_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[NS-2] && dv[F].hue_en && !dv[F].hue_of |-> dv[F].hue_rem < dv[F].hue_div)
    else $error("hue remainder not below divisor");

endmodule

/* sim/rgb_to_hsv_converter_top_test.sv */
`timescale 1ns / 100ps

module rgb_to_hsv_converter_top_test;
  import rgbhsv_pkg::*;

  localparam int COMP_BITS = COMPONENT_BITS_DEFAULT;
  localparam int FRAC_BITS = FRACTION_BITS_DEFAULT;
  localparam longint unsigned FULL_SCALE = (64'd1 << FRAC_BITS) - 1;
  localparam int SETTLE_CYCLES = FRAC_BITS + 10;

  typedef enum int {FLOW_STEADY, FLOW_LIGHT, FLOW_HEAVY} flow_mode_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]  hue;
    logic [OUT_BITS-1:0]  saturation;
    logic [COMP_BITS-1:0] brightness;
  } hsv_t;

  logic clk = 1'b0;
  logic rst;
  logic pixel_valid;
  logic pixel_ready;
  logic [COMP_BITS-1:0] red;
  logic [COMP_BITS-1:0] green;
  logic [COMP_BITS-1:0] blue;
  logic hsv_valid;
  logic hsv_ready = 1'b0;
  logic [OUT_BITS-1:0] hue;
  logic [OUT_BITS-1:0] saturation;
  logic [COMP_BITS-1:0] brightness;
  logic write_enable;
  logic write_index;
  logic [GAIN_BITS-1:0] write_data;

  logic [GAIN_BITS-1:0] hue_gain_model = GAIN_RESET;
  logic [GAIN_BITS-1:0] sat_gain_model = GAIN_RESET;
  hsv_t hsv_pending[$];
  int mismatch_count = 0;
  int ready_hold = 0;
  flow_mode_t sender_mode = FLOW_LIGHT;
  flow_mode_t receiver_mode = FLOW_LIGHT;

  rgb_to_hsv_converter_top DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .hsv_valid(hsv_valid),
    .hsv_ready(hsv_ready),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [OUT_BITS-1:0] scale_by_gain(input longint unsigned num,
                                                         input longint unsigned den,
                                                         input logic [GAIN_BITS-1:0] gain);
    longint unsigned top;
    longint unsigned bot;
    longint unsigned quot;
    top = (num * gain) << FRAC_BITS;
    bot = den << GAIN_FRAC;
    quot = top / bot;
    if (quot > FULL_SCALE) begin
      quot = FULL_SCALE;
    end
    return quot[OUT_BITS-1:0];
  endfunction

  function automatic hsv_t predict_hsv(input logic [COMP_BITS-1:0] r,
                                       input logic [COMP_BITS-1:0] g,
                                       input logic [COMP_BITS-1:0] b);
    longint rv;
    longint gv;
    longint bv;
    longint hi;
    longint lo;
    longint spread;
    longint num;
    hsv_t res;
    rv = r;
    gv = g;
    bv = b;
    hi = rv;
    lo = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    spread = hi - lo;
    res.hue = '0;
    res.saturation = '0;
    res.brightness = hi[COMP_BITS-1:0];
    if (hi != 0) begin
      res.saturation = scale_by_gain(spread, hi, sat_gain_model);
    end
    if (spread != 0) begin
      if (rv == hi) begin
        num = gv - bv;
      end else if (gv == hi) begin
        num = 2 * spread + bv - rv;
      end else begin
        num = 4 * spread + rv - gv;
      end
      if (num < 0) begin
        num = num + 6 * spread;
      end
      res.hue = scale_by_gain(num, 6 * spread, hue_gain_model);
    end
    return res;
  endfunction

  function automatic bit wants_gap(input flow_mode_t mode);
    if (mode == FLOW_STEADY) begin
      return 1'b0;
    end else if (mode == FLOW_LIGHT) begin
      return $urandom_range(0, 3) == 0;
    end
    return $urandom_range(0, 1) == 0;
  endfunction

  function automatic int pick_gap(input flow_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ((mode == FLOW_HEAVY) ? 50 : 80)) begin
      return $urandom_range(1, 3);
    end else if (roll < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [GAIN_BITS-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_RESET;
      3: return GAIN_BITS'($urandom_range(0, 4096));
      4: return GAIN_BITS'($urandom_range(4096, 8192));
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [3*COMP_BITS-1:0] corner_pixel(input int idx);
    case (idx)
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return 24'h808080;
      3: return 24'h010101;
      4: return 24'hff0000;
      5: return 24'h00ff00;
      6: return 24'h0000ff;
      7: return 24'hffff00;
      8: return 24'h00ffff;
      9: return 24'hff00ff;
      10: return 24'hff0ac8;
      11: return 24'h010000;
      12: return 24'h000100;
      13: return 24'h000001;
      14: return 24'hc86464;
      15: return 24'hfffe00;
      16: return 24'hfe00ff;
      17: return 24'haa5500;
      18: return 24'h7f8081;
      default: return 24'h55aaff;
    endcase
  endfunction

  task automatic random_pixel(output logic [COMP_BITS-1:0] r,
                              output logic [COMP_BITS-1:0] g,
                              output logic [COMP_BITS-1:0] b);
    logic [COMP_BITS-1:0] a;
    logic [COMP_BITS-1:0] c;
    a = COMP_BITS'($urandom);
    c = COMP_BITS'($urandom);
    r = COMP_BITS'($urandom);
    g = COMP_BITS'($urandom);
    b = COMP_BITS'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        r = a;
        g = a;
        b = a;
      end
      1: begin
        r = a;
        g = a;
        b = c;
      end
      2: begin
        g = a;
        b = a;
        r = c;
      end
      3: begin
        r = a;
        b = a;
        g = c;
      end
      4: begin
        r = $urandom_range(0, 1) ? '1 : '0;
        g = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : '0;
      end
      5: begin
        r = COMP_BITS'($urandom_range(0, 3));
        g = COMP_BITS'($urandom_range(0, 3));
        b = COMP_BITS'($urandom_range(0, 3));
      end
      default: begin
      end
    endcase
  endtask

  // Expectations are queued at the same edge that completes the pixel transfer.
  task automatic send_pixel(input logic [COMP_BITS-1:0] r,
                            input logic [COMP_BITS-1:0] g,
                            input logic [COMP_BITS-1:0] b);
    @(negedge clk);
    pixel_valid = 1'b1;
    red = r;
    green = g;
    blue = b;
    do @(posedge clk); while (!pixel_ready);
    hsv_pending.push_back(predict_hsv(r, g, b));
  endtask

  task automatic sender_pause();
    int gap;
    if (wants_gap(sender_mode)) begin
      gap = pick_gap(sender_mode);
      @(negedge clk);
      pixel_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    pixel_valid = 1'b0;
    while (hsv_pending.size() != 0) @(posedge clk);
  endtask

  task automatic settle_pipeline();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [GAIN_BITS-1:0] data);
    @(negedge clk);
    write_enable = 1'b1;
    write_index = idx;
    write_data = data;
    @(negedge clk);
    write_enable = 1'b0;
    if (idx == REG_HUE_GAIN) begin
      hue_gain_model = data;
    end else begin
      sat_gain_model = data;
    end
  endtask

  task automatic set_gains(input logic [GAIN_BITS-1:0] hue_gain,
                           input logic [GAIN_BITS-1:0] sat_gain);
    write_register(REG_HUE_GAIN, hue_gain);
    write_register(REG_SATURATION_GAIN, sat_gain);
  endtask

  task automatic test_reset_gains();
    logic [3*COMP_BITS-1:0] px;
    sender_mode = FLOW_LIGHT;
    receiver_mode = FLOW_LIGHT;
    for (int i = 0; i < 20; i++) begin
      px = corner_pixel(i);
      sender_pause();
      send_pixel(px[23:16], px[15:8], px[7:0]);
    end
  endtask

  task automatic test_gain_extremes();
    logic [GAIN_BITS-1:0] hue_set[4];
    logic [GAIN_BITS-1:0] sat_set[4];
    logic [3*COMP_BITS-1:0] px;
    logic [COMP_BITS-1:0] r;
    logic [COMP_BITS-1:0] g;
    logic [COMP_BITS-1:0] b;
    hue_set = '{16'h0000, 16'hffff, 16'h0001, 16'h0fff};
    sat_set = '{16'hffff, 16'h0000, 16'h0001, 16'h1001};
    for (int s = 0; s < 4; s++) begin
      settle_pipeline();
      set_gains(hue_set[s], sat_set[s]);
      for (int i = 0; i < 12; i++) begin
        if (i < 6) begin
          px = corner_pixel($urandom_range(0, 19));
          r = px[23:16];
          g = px[15:8];
          b = px[7:0];
        end else begin
          random_pixel(r, g, b);
        end
        sender_pause();
        send_pixel(r, g, b);
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [COMP_BITS-1:0] r;
    logic [COMP_BITS-1:0] g;
    logic [COMP_BITS-1:0] b;
    for (int phase = 0; phase < 7; phase++) begin
      settle_pipeline();
      if (phase == 0) begin
        set_gains(GAIN_RESET, GAIN_RESET);
      end else begin
        set_gains(random_gain(), random_gain());
      end
      if (phase == 1) begin
        sender_mode = FLOW_STEADY;
        receiver_mode = FLOW_STEADY;
      end else begin
        sender_mode = flow_mode_t'($urandom_range(0, 2));
        receiver_mode = flow_mode_t'($urandom_range(0, 2));
      end
      for (int i = 0; i < 60; i++) begin
        random_pixel(r, g, b);
        sender_pause();
        send_pixel(r, g, b);
      end
    end
  endtask

  // Bursts into a stalling receiver (the last burst: a gapped sender into a ready receiver),
  // stopping after each burst until every result has been taken.
  task automatic test_backpressure();
    logic [COMP_BITS-1:0] r;
    logic [COMP_BITS-1:0] g;
    logic [COMP_BITS-1:0] b;
    sender_mode = FLOW_STEADY;
    receiver_mode = FLOW_HEAVY;
    for (int burst = 0; burst < 5; burst++) begin
      if (burst == 4) begin
        sender_mode = FLOW_HEAVY;
        receiver_mode = FLOW_STEADY;
      end
      for (int i = 0; i < 10; i++) begin
        random_pixel(r, g, b);
        sender_pause();
        send_pixel(r, g, b);
      end
      hold_until_drained();
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      hsv_ready <= 1'b0;
    end else if (wants_gap(receiver_mode)) begin
      ready_hold <= pick_gap(receiver_mode) - 1;
      hsv_ready <= 1'b0;
    end else begin
      hsv_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    hsv_t want;
    if (!rst && hsv_valid && hsv_ready) begin
      if (hsv_pending.size() == 0) begin
        $display("%0t: result transfer with nothing expected: hue %0d saturation %0d brightness %0d",
                 $time, hue, saturation, brightness);
        mismatch_count++;
      end else begin
        want = hsv_pending.pop_front();
        if (hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
          mismatch_count++;
        end
        if (saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d actual %0d", $time, want.saturation,
                   saturation);
          mismatch_count++;
        end
        if (brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d actual %0d", $time, want.brightness,
                   brightness);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    write_enable = 1'b0;
    write_index = REG_HUE_GAIN;
    write_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_gains();
    test_gain_extremes();
    test_random_traffic();
    test_backpressure();
    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rgbhsv_pkg.sv
rtl/core/rgb_to_hsv_converter_top.sv
sim/rgb_to_hsv_converter_top_test.sv
